// ===== design/constrained_iss_clustering_macros.svh =====
// Assertion helpers shared by the clustering block
`ifndef CONSTRAINED_ISS_CLUSTERING_MACROS_SVH
`define CONSTRAINED_ISS_CLUSTERING_MACROS_SVH

// Condition must never hold outside reset
`define CISS_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CISS_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define CISS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ciss_pkg.sv =====
package ciss_pkg;

   // Default sizing
   localparam int MAX_SAMPLES_DEF = 64;
   localparam int DIST_WIDTH_DEF  = 40;

   // Fixed field widths
   localparam int IN_W     = 32;
   localparam int NSAMP_W  = 7;
   localparam int IDX_W    = 6;
   localparam int HEIGHT_W = 48;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

endpackage

// ===== design/ciss_arith.sv =====
// Shared update unit: three products through one multiplier, a compare,
// then a restoring divide one quotient bit per cycle with rounding and
// saturation.
module ciss_arith #(
   parameter int DW = ciss_pkg::DIST_WIDTH_DEF,
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] d1,
   input  logic [DW-1:0] d2,
   input  logic [DW-1:0] dmin,
   input  logic [CW-1:0] w1,
   input  logic [CW-1:0] w2,
   input  logic [CW-1:0] w3,
   input  logic [CW-1:0] den,
   output logic          done,
   output logic [DW-1:0] result
);

   localparam int PRW = DW + CW;
   localparam int SW  = PRW + 1;
   localparam int NW  = SW + 1;
   localparam int KW  = $clog2(NW + 1);

   typedef enum logic [6:0] {
      A_IDLE = 7'b0000001,
      A_M1   = 7'b0000010,
      A_M2   = 7'b0000100,
      A_M3   = 7'b0001000,
      A_CHK  = 7'b0010000,
      A_DIV  = 7'b0100000,
      A_SAT  = 7'b1000000
   } astate_type;

   astate_type state_ff, state_in;
   logic [DW-1:0]  d1_ff, d1_in, d2_ff, d2_in, dm_ff, dm_in;
   logic [CW-1:0]  w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in, den_ff, den_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [SW-1:0]  acc_ff, acc_in;
   logic [NW-1:0]  num_ff, num_in;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [KW-1:0]  cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [DW-1:0]  res_ff, res_in;
   logic [DW-1:0]  mul_a;
   logic [CW-1:0]  mul_b;
   logic [CW:0]    trial;

   // Select multiplier operands
   always_comb begin
      case (state_ff)
         A_M1:    begin mul_a = d1_ff; mul_b = w1_ff; end
         A_M2:    begin mul_a = d2_ff; mul_b = w2_ff; end
         default: begin mul_a = dm_ff; mul_b = w3_ff; end
      endcase
   end

   assign prod_in = PRW'(mul_a) * PRW'(mul_b);
   assign trial   = {rem_ff, num_ff[NW-1]};

   // Sequence the update
   always_comb begin
      state_in = state_ff;
      d1_in = d1_ff; d2_in = d2_ff; dm_in = dm_ff;
      w1_in = w1_ff; w2_in = w2_ff; w3_in = w3_ff; den_in = den_ff;
      acc_in = acc_ff; num_in = num_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      done_in = 1'b0; res_in = res_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               d1_in = d1; d2_in = d2; dm_in = dmin;
               w1_in = w1; w2_in = w2; w3_in = w3; den_in = den;
               state_in = A_M1;
            end
         end
         A_M1: state_in = A_M2;
         A_M2: begin
            acc_in   = SW'(prod_ff);
            state_in = A_M3;
         end
         A_M3: begin
            acc_in   = acc_ff + SW'(prod_ff);
            state_in = A_CHK;
         end
         A_CHK: begin
            if (acc_ff <= SW'(prod_ff)) begin
               res_in   = '0;
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               num_in   = NW'(acc_ff - SW'(prod_ff)) + NW'(den_ff >> 1);
               rem_in   = '0;
               cnt_in   = KW'(NW);
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = CW'(trial - {1'b0, den_ff});
               num_in = {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial[CW-1:0];
               num_in = {num_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - KW'(1);
            if (cnt_ff == KW'(1)) state_in = A_SAT;
         end
         A_SAT: begin
            res_in   = (|num_ff[NW-1:DW]) ? {DW{1'b1}} : num_ff[DW-1:0];
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      d1_ff <= d1_in; d2_ff <= d2_in; dm_ff <= dm_in;
      w1_ff <= w1_in; w2_ff <= w2_in; w3_ff <= w3_in; den_ff <= den_in;
      prod_ff <= prod_in; acc_ff <= acc_in; num_ff <= num_in;
      rem_ff <= rem_in; cnt_ff <= cnt_in; res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== design/constrained_iss_clustering.sv =====
// Constrained incremental-sum-of-squares clustering of an ordered sequence.
// Load the lower triangle of the dissimilarity matrix row by row, one
// element per cycle, with tlast on the final element; then the block stops
// taking input and clusters. Each run first sweeps the size and label
// memories, then for each of the N-1 merges walks the adjacent pairs for the
// minimum, updates distances to the merged cluster in the shared arithmetic
// unit (which skips its divide when the update clamps to zero) and shifts the
// distance memory down. Results come out one per sample 1..N-1, and the next
// matrix is accepted once the last result is taken.
module constrained_iss_clustering #(
   parameter int MAX_SAMPLES = ciss_pkg::MAX_SAMPLES_DEF,
   parameter int DIST_WIDTH  = ciss_pkg::DIST_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] distance
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [5:0] sample_index, [53:6] height, [55:54] zero
   output logic        rsp_tlast,   // final_res
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // num_samples
);

   `include "constrained_iss_clustering_macros.svh"

   localparam int DW     = DIST_WIDTH;
   localparam int HW     = ciss_pkg::HEIGHT_W;
   localparam int DEPTH  = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTRW   = $clog2(DEPTH + 1);
   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int LW     = $clog2(MAX_SAMPLES);
   localparam int NCW    = (CW > ciss_pkg::NSAMP_W) ? CW : ciss_pkg::NSAMP_W;
   localparam int TW     = ((DW > HW) ? DW : HW) + 1;
   localparam int ST_W   = 34;

   typedef enum logic [ST_W-1:0] {
      S_LOAD     = (34'd1 << 0),
      S_INIT     = (34'd1 << 1),
      S_MIN_RD   = (34'd1 << 2),
      S_MIN_CMP  = (34'd1 << 3),
      S_LP_RD    = (34'd1 << 4),
      S_LQ_RD    = (34'd1 << 5),
      S_LQ_GET   = (34'd1 << 6),
      S_NP_RD    = (34'd1 << 7),
      S_NQ_RD    = (34'd1 << 8),
      S_NQ_GET   = (34'd1 << 9),
      S_TOT      = (34'd1 << 10),
      S_J1_CHK   = (34'd1 << 11),
      S_U_LRD    = (34'd1 << 12),
      S_U_NRD    = (34'd1 << 13),
      S_U_D1RD   = (34'd1 << 14),
      S_U_D2RD   = (34'd1 << 15),
      S_U_START  = (34'd1 << 16),
      S_U_WAIT   = (34'd1 << 17),
      S_U_WR     = (34'd1 << 18),
      S_SH_CHK   = (34'd1 << 19),
      S_SH_RD    = (34'd1 << 20),
      S_SH_WR    = (34'd1 << 21),
      S_L2_CHK   = (34'd1 << 22),
      S_L3J_CHK  = (34'd1 << 23),
      S_L3I_CHK  = (34'd1 << 24),
      S_L3_RD    = (34'd1 << 25),
      S_L3_WR    = (34'd1 << 26),
      S_LB_CHK   = (34'd1 << 27),
      S_LB_RD    = (34'd1 << 28),
      S_LB_WR    = (34'd1 << 29),
      S_CSZ_WR   = (34'd1 << 30),
      S_OUT_RD   = (34'd1 << 31),
      S_OUT_GET  = (34'd1 << 32),
      S_OUT_WAIT = (34'd1 << 33)
   } state_type;

   // Memories
   logic [DW-1:0] pd_mem  [DEPTH];
   logic [CW-1:0] csz_mem [MAX_SAMPLES];
   logic [LW-1:0] lbl_mem [MAX_SAMPLES];
   logic [HW-1:0] mh_mem  [MAX_SAMPLES];

   state_type state_ff, state_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [PTRW-1:0] lptr_ff, lptr_in;
   logic [LW-1:0]   sweep_ff, sweep_in;
   logic [CW-1:0]   msiz_ff, msiz_in, iter_ff, iter_in;
   logic [CW-1:0]   k_ff, k_in, p_ff, p_in, j_ff, j_in, i_ff, i_in, uj_ff, uj_in;
   logic            mode_ff, mode_in;
   logic [DW-1:0]   dmin_ff, dmin_in, d1_ff, d1_in;
   logic [CW-1:0]   np_ff, np_in, nq_ff, nq_in, nr_ff, nr_in;
   logic [LW-1:0]   lp_ff, lp_in, lq_ff, lq_in;
   logic [HW-1:0]   total_ff, total_in, total_nx;
   logic            rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [HW-1:0]   rheight_ff, rheight_in;
   logic [ciss_pkg::IDX_W-1:0] ridx_ff, ridx_in;

   logic [DW-1:0]   pd_rd_ff, pd_wdata;
   logic [CW-1:0]   csz_rd_ff, csz_wdata;
   logic [LW-1:0]   lbl_rd_ff, lbl_wdata;
   logic [HW-1:0]   mh_rd_ff;
   logic [AW-1:0]   pd_raddr, pd_waddr;
   logic [LW-1:0]   csz_raddr, csz_waddr, lbl_raddr, lbl_waddr, mh_raddr;
   logic            pd_we, csz_we, lbl_we, mh_we;
   logic [CW-1:0]   ra, rb, wa, wb;
   logic            pd_wsel;
   logic [CW-1:0]   q;
   logic [DW+31:0]  din_ext;
   logic [DW-1:0]   din_sat;
   logic [NCW-1:0]  wext;
   logic            ar_start, ar_done;
   logic [DW-1:0]   ar_result;
   logic [TW-1:0]   room;

   // Map a pair of 1-based positions to its lower-triangle slot
   function automatic logic [AW-1:0] pidx(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW-1:0]   r, c;
      logic [2*CW-1:0] t;
      begin
         if (a < b) begin
            r = b - CW'(1);
            c = a - CW'(1);
         end else begin
            r = a - CW'(1);
            c = b - CW'(1);
         end
         t    = (2*CW)'(r) * (2*CW)'(r - CW'(1));
         pidx = AW'((t >> 1) + (2*CW)'(c));
      end
   endfunction

   assign q        = p_ff + CW'(1);
   assign din_ext  = {{DW{1'b0}}, req_tdata};
   assign din_sat  = (|din_ext[DW+31:DW]) ? {DW{1'b1}} : din_ext[DW-1:0];
   assign wext     = NCW'(csr_wdata);

   // Saturating dispersion accumulate
   assign room     = TW'(ciss_pkg::HEIGHT_MAX) - TW'(total_ff);
   assign total_nx = (TW'(dmin_ff) >= room) ? ciss_pkg::HEIGHT_MAX
                                            : HW'(TW'(total_ff) + TW'(dmin_ff));

   // Distance memory address selection
   always_comb begin
      ra = k_ff + CW'(1);
      rb = k_ff;
      case (state_ff)
         S_U_D1RD: begin ra = uj_ff;           rb = p_ff; end
         S_U_D2RD: begin ra = uj_ff;           rb = q;    end
         S_SH_RD:  begin ra = i_ff + CW'(1);   rb = j_ff; end
         S_L3_RD:  begin ra = i_ff + CW'(1);   rb = j_ff + CW'(1); end
         default:  begin ra = k_ff + CW'(1);   rb = k_ff; end
      endcase
      pd_wsel = (state_ff == S_U_WR) && !mode_ff;
      wa      = pd_wsel ? p_ff : i_ff;
      wb      = (pd_wsel || (state_ff != S_U_WR)) ? j_ff : p_ff;
   end

   assign pd_raddr  = pidx(ra, rb);
   assign pd_waddr  = (state_ff == S_LOAD) ? lptr_ff[AW-1:0] : pidx(wa, wb);
   assign pd_we     = ((state_ff == S_LOAD) && req_tvalid && (lptr_ff < PTRW'(DEPTH)))
                    || (state_ff == S_U_WR) || (state_ff == S_SH_WR)
                    || (state_ff == S_L3_WR);
   assign pd_wdata  = (state_ff == S_LOAD) ? din_sat
                    : (state_ff == S_U_WR) ? ar_result : pd_rd_ff;

   // Label and size memory ports
   always_comb begin
      case (state_ff)
         S_LP_RD: lbl_raddr = LW'(p_ff - CW'(1));
         S_LQ_RD: lbl_raddr = LW'(p_ff);
         S_U_LRD: lbl_raddr = LW'(uj_ff - CW'(1));
         default: lbl_raddr = LW'(i_ff);
      endcase
      case (state_ff)
         S_NP_RD: csz_raddr = lp_ff;
         S_NQ_RD: csz_raddr = lq_ff;
         default: csz_raddr = lbl_rd_ff;
      endcase
   end

   assign lbl_we    = (state_ff == S_INIT) || (state_ff == S_LB_WR);
   assign lbl_waddr = (state_ff == S_INIT) ? sweep_ff : LW'(i_ff - CW'(1));
   assign lbl_wdata = (state_ff == S_INIT) ? sweep_ff : lbl_rd_ff;
   assign csz_we    = (state_ff == S_INIT) || (state_ff == S_CSZ_WR);
   assign csz_waddr = (state_ff == S_INIT) ? sweep_ff : lp_ff;
   assign csz_wdata = (state_ff == S_INIT) ? CW'(1) : (np_ff + nq_ff);
   assign mh_we     = (state_ff == S_TOT);
   assign mh_raddr  = LW'(k_ff);

   always_ff @(posedge clock) begin
      if (pd_we) pd_mem[pd_waddr] <= pd_wdata;
      pd_rd_ff <= pd_mem[pd_raddr];
      if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
      lbl_rd_ff <= lbl_mem[lbl_raddr];
      if (csz_we) csz_mem[csz_waddr] <= csz_wdata;
      csz_rd_ff <= csz_mem[csz_raddr];
      if (mh_we) mh_mem[lq_ff] <= total_nx;
      mh_rd_ff <= mh_mem[mh_raddr];
   end

   assign ar_start = (state_ff == S_U_START);

   ciss_arith #(
      .DW(DW),
      .CW(CW)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (ar_start),
      .d1     (d1_ff),
      .d2     (pd_rd_ff),
      .dmin   (dmin_ff),
      .w1     (nr_ff + np_ff),
      .w2     (nr_ff + nq_ff),
      .w3     (nr_ff),
      .den    (nr_ff + np_ff + nq_ff),
      .done   (ar_done),
      .result (ar_result)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; lptr_in = lptr_ff; sweep_in = sweep_ff;
      msiz_in = msiz_ff; iter_in = iter_ff; k_in = k_ff; p_in = p_ff;
      j_in = j_ff; i_in = i_ff; uj_in = uj_ff; mode_in = mode_ff;
      dmin_in = dmin_ff; d1_in = d1_ff; np_in = np_ff; nq_in = nq_ff; nr_in = nr_ff;
      lp_in = lp_ff; lq_in = lq_ff; total_in = total_ff;
      rvalid_in = rvalid_ff; rlast_in = rlast_ff; rheight_in = rheight_ff;
      ridx_in = ridx_ff;

      // Clamp the sample count on write
      if (csr_we) begin
         if (wext < NCW'(2))                n_in = CW'(2);
         else if (wext > NCW'(MAX_SAMPLES)) n_in = CW'(MAX_SAMPLES);
         else                               n_in = wext[CW-1:0];
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (lptr_ff < PTRW'(DEPTH)) lptr_in = lptr_ff + PTRW'(1);
               if (req_tlast) begin
                  sweep_in = '0;
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            sweep_in = sweep_ff + LW'(1);
            if (sweep_ff == LW'(MAX_SAMPLES - 1)) begin
               total_in = '0;
               msiz_in  = n_ff - CW'(1);
               iter_in  = CW'(1);
               k_in     = CW'(1);
               state_in = S_MIN_RD;
            end
         end
         S_MIN_RD: state_in = S_MIN_CMP;
         S_MIN_CMP: begin
            if ((k_ff == CW'(1)) || (pd_rd_ff < dmin_ff)) begin
               dmin_in = pd_rd_ff;
               p_in    = k_ff;
            end
            if (k_ff == msiz_ff) begin
               state_in = S_LP_RD;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_MIN_RD;
            end
         end
         S_LP_RD:  state_in = S_LQ_RD;
         S_LQ_RD: begin
            lp_in    = lbl_rd_ff;
            state_in = S_LQ_GET;
         end
         S_LQ_GET: begin
            lq_in    = lbl_rd_ff;
            state_in = S_NP_RD;
         end
         S_NP_RD:  state_in = S_NQ_RD;
         S_NQ_RD: begin
            np_in    = csz_rd_ff;
            state_in = S_NQ_GET;
         end
         S_NQ_GET: begin
            nq_in    = csz_rd_ff;
            state_in = S_TOT;
         end
         S_TOT: begin
            total_in = total_nx;
            j_in     = CW'(1);
            state_in = S_J1_CHK;
         end
         // Rows above the merged pair
         S_J1_CHK: begin
            if (j_ff < p_ff) begin
               uj_in    = j_ff;
               mode_in  = 1'b0;
               state_in = S_U_LRD;
            end else begin
               i_in     = q;
               state_in = S_L2_CHK;
            end
         end
         S_U_LRD:  state_in = S_U_NRD;
         S_U_NRD:  state_in = S_U_D1RD;
         S_U_D1RD: begin
            nr_in    = csz_rd_ff;
            state_in = S_U_D2RD;
         end
         S_U_D2RD: begin
            d1_in    = pd_rd_ff;
            state_in = S_U_START;
         end
         S_U_START: state_in = S_U_WAIT;
         S_U_WAIT:  if (ar_done) state_in = S_U_WR;
         S_U_WR: begin
            if (!mode_ff) begin
               i_in     = q;
               state_in = S_SH_CHK;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_L2_CHK;
            end
         end
         // Close the gap in column j
         S_SH_CHK: begin
            if (i_ff <= msiz_ff) begin
               state_in = S_SH_RD;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_J1_CHK;
            end
         end
         S_SH_RD: state_in = S_SH_WR;
         S_SH_WR: begin
            i_in     = i_ff + CW'(1);
            state_in = S_SH_CHK;
         end
         // Rows below the merged pair
         S_L2_CHK: begin
            if (i_ff <= msiz_ff) begin
               uj_in    = i_ff + CW'(1);
               mode_in  = 1'b1;
               state_in = S_U_LRD;
            end else begin
               j_in     = q;
               state_in = S_L3J_CHK;
            end
         end
         // Move the lower block up and left
         S_L3J_CHK: begin
            if (j_ff < msiz_ff) begin
               i_in     = j_ff + CW'(1);
               state_in = S_L3I_CHK;
            end else begin
               i_in     = q;
               state_in = S_LB_CHK;
            end
         end
         S_L3I_CHK: begin
            if (i_ff <= msiz_ff) begin
               state_in = S_L3_RD;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_L3J_CHK;
            end
         end
         S_L3_RD: state_in = S_L3_WR;
         S_L3_WR: begin
            i_in     = i_ff + CW'(1);
            state_in = S_L3I_CHK;
         end
         // Shift labels down
         S_LB_CHK: state_in = (i_ff <= msiz_ff) ? S_LB_RD : S_CSZ_WR;
         S_LB_RD:  state_in = S_LB_WR;
         S_LB_WR: begin
            i_in     = i_ff + CW'(1);
            state_in = S_LB_CHK;
         end
         S_CSZ_WR: begin
            msiz_in = msiz_ff - CW'(1);
            iter_in = iter_ff + CW'(1);
            k_in    = CW'(1);
            if (iter_ff + CW'(1) < n_ff) state_in = S_MIN_RD;
            else                         state_in = S_OUT_RD;
         end
         // Deliver heights
         S_OUT_RD: state_in = S_OUT_GET;
         S_OUT_GET: begin
            rheight_in = mh_rd_ff;
            ridx_in    = k_ff[ciss_pkg::IDX_W-1:0];
            rlast_in   = (k_ff == n_ff - CW'(1));
            rvalid_in  = 1'b1;
            state_in   = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               if (rlast_ff) begin
                  lptr_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         n_ff      <= CW'(2);
         lptr_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         lptr_ff   <= lptr_in;
         rvalid_ff <= rvalid_in;
      end
      sweep_ff <= sweep_in; msiz_ff <= msiz_in; iter_ff <= iter_in;
      k_ff <= k_in; p_ff <= p_in; j_ff <= j_in; i_ff <= i_in; uj_ff <= uj_in;
      mode_ff <= mode_in; dmin_ff <= dmin_in; d1_ff <= d1_in;
      np_ff <= np_in; nq_ff <= nq_in; nr_ff <= nr_in;
      lp_ff <= lp_in; lq_ff <= lq_in; total_ff <= total_in;
      rlast_ff <= rlast_in; rheight_ff <= rheight_in; ridx_ff <= ridx_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {2'b00, rheight_ff, ridx_ff};

   `CISS_NEVER(a_no_overlap, req_tready && rsp_tvalid, "input taken while result pending")
   `CISS_IMPLY(a_done_in_wait, ar_done, state_ff == S_U_WAIT, "arith done outside wait")
   `CISS_IMPLY(a_valid_state, rsp_tvalid, state_ff == S_OUT_WAIT, "result valid in wrong state")
   `CISS_NEXT(a_last_returns, rsp_tvalid && rsp_tready && rsp_tlast, req_tready,
              "load not resumed after final result")

endmodule
